@@ rtl/lwt_pkg.sv @@
package lwt_pkg;

  // Coordinate width of point columns and rows.
  localparam int COORD_BITS = 12;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_ROI_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_SIDE_MARGIN   = 2'd2;
  localparam logic [1:0] REG_WARMUP_FRAMES = 2'd3;

  localparam logic [11:0] FRAME_WIDTH_RST   = 12'd640;
  localparam logic [11:0] ROI_HEIGHT_RST    = 12'd160;
  localparam logic [7:0]  SIDE_MARGIN_RST   = 8'd20;
  localparam logic [15:0] WARMUP_FRAMES_RST = 16'd20;

  // Input mode codes.
  localparam logic [1:0] MODE_POINT = 2'd0;
  localparam logic [1:0] MODE_LAST  = 2'd1;
  localparam logic [1:0] MODE_EOF   = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Result action codes.
  localparam logic [1:0] ACT_REFIT      = 2'd0;
  localparam logic [1:0] ACT_KEEP_MANY  = 2'd1;
  localparam logic [1:0] ACT_RESET_WIDE = 2'd2;
  localparam logic [1:0] ACT_KEEP_NONE  = 2'd3;

  // Box geometry.
  localparam logic signed [13:0] CENTRE_HALF_SPAN = 14'sd100;
  localparam logic signed [13:0] WIDE_X_INSET     = 14'sd30;
  localparam logic signed [13:0] BOX_Y_TOP        = 14'sd2;
  localparam logic signed [13:0] WIDE_Y_INSET     = 14'sd2;
  localparam logic [7:0]         REFIT_MAX_COUNT  = 8'd4;
  localparam logic [7:0]         COUNT_MAX        = 8'hFF;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_LAST  = 2'd1,
    KIND_EOF   = 2'd2
  } lwt_kind_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] roi_height;
    logic [7:0]  side_margin;
    logic [15:0] warmup_frames;
  } lwt_cfg_t;

  typedef struct packed {
    lwt_kind_t   kind;
    logic [11:0] px;
    logic [11:0] py;
    logic        warm;
  } lwt_entry_t;

endpackage

@@ rtl/lwt_regs.sv @@
module lwt_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output lwt_pkg::lwt_cfg_t cfg
);
  import lwt_pkg::*;

  lwt_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= FRAME_WIDTH_RST;
      cfg_r.roi_height    <= ROI_HEIGHT_RST;
      cfg_r.side_margin   <= SIDE_MARGIN_RST;
      cfg_r.warmup_frames <= WARMUP_FRAMES_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_pwdata[11:0];
        REG_ROI_HEIGHT:    cfg_r.roi_height    <= cfg_pwdata[11:0];
        REG_SIDE_MARGIN:   cfg_r.side_margin   <= cfg_pwdata[7:0];
        REG_WARMUP_FRAMES: cfg_r.warmup_frames <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:   cfg_prdata = {20'd0, cfg_r.frame_width};
      REG_ROI_HEIGHT:    cfg_prdata = {20'd0, cfg_r.roi_height};
      REG_SIDE_MARGIN:   cfg_prdata = {24'd0, cfg_r.side_margin};
      REG_WARMUP_FRAMES: cfg_prdata = {16'd0, cfg_r.warmup_frames};
      default:           cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/lwt_front.sv @@
module lwt_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,
  input  logic [39:0]         in_tdata,
  input  lwt_pkg::lwt_cfg_t   cfg,
  input  logic                q_full,
  output logic                q_push,
  output lwt_pkg::lwt_entry_t q_entry
);
  import lwt_pkg::*;

  logic        accept;
  logic        keep;
  logic [15:0] frame_index;

  assign in_tready   = !q_full;
  assign accept      = in_tvalid && in_tready;
  assign frame_index = in_tdata[39:24];

  always_comb begin
    keep         = 1'b1;
    q_entry.kind = KIND_POINT;
    unique case (in_tuser)
      MODE_POINT: q_entry.kind = KIND_POINT;
      MODE_LAST:  q_entry.kind = KIND_LAST;
      MODE_EOF:   q_entry.kind = KIND_EOF;
      MODE_NONE:  keep = 1'b0;
      default:    keep = 1'b0;
    endcase
    q_entry.px   = in_tdata[11:0];
    q_entry.py   = in_tdata[23:12];
    // Warm-up per item; keep configuration stable while items are in flight (not enforced here).
    q_entry.warm = frame_index <= cfg.warmup_frames;
  end

  // Items with the unused mode code are taken and discarded here.
  assign q_push = accept && keep;

endmodule

@@ rtl/lwt_queue.sv @@
module lwt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid,
  output logic             full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign valid   = count_r != '0;
  assign full    = count_r == FULL_CNT;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/lwt_back.sv @@
module lwt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lwt_pkg::lwt_cfg_t   cfg,
  input  logic                q_valid,
  input  lwt_pkg::lwt_entry_t q_entry,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [1:0]          out_tuser,
  output logic [63:0]         out_tdata
);
  import lwt_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;
  localparam coord_t COORD_ONES = '1;

  // Window and tracking state.
  logic signed [13:0] wx_min_r, wx_max_r, wy_min_r, wy_max_r;
  logic signed [13:0] wx_min_nxt, wx_max_nxt, wy_min_nxt, wy_max_nxt;
  logic               inside_r, inside_nxt;
  coord_t             cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  coord_t             fmin_r, fmin_nxt, fmax_r, fmax_nxt;
  logic [7:0]         acc_r, acc_nxt, cnt_r, cnt_nxt;

  // Output register.
  logic               out_valid_r;
  logic signed [13:0] o_l_r, o_r_r, o_t_r, o_b_r;
  logic [7:0]         o_acc_r;
  logic [1:0]         o_act_r;

  logic               out_free, is_eof, is_pt, do_eof;
  coord_t             px, py;
  coord_t             cmin_pt, cmax_pt;
  logic               in_box, inside_pt;
  logic signed [14:0] px_s, py_s;
  logic signed [13:0] half_s, fw_s, rh_s, wide_x_r, wide_y_b;
  logic signed [13:0] c_l, c_r, c_t, c_b;
  logic signed [13:0] w_l, w_r, w_t, w_b;
  logic signed [13:0] t_l, t_r, t_t, t_b;
  logic signed [13:0] n_l, n_r, n_t, n_b;
  logic signed [13:0] margin_s;
  logic [1:0]         n_act;

  assign out_free = !out_valid_r || out_tready;
  assign is_eof   = q_entry.kind == KIND_EOF;
  assign q_pop    = q_valid && (!is_eof || out_free);
  assign is_pt    = q_pop && !is_eof;
  assign do_eof   = q_pop && is_eof;

  assign px   = COORD_BITS'(q_entry.px);
  assign py   = COORD_BITS'(q_entry.py);
  assign px_s = signed'(15'(px));
  assign py_s = signed'(15'(py));

  // Centred and wide boxes follow the configuration.
  assign half_s   = signed'({3'b000, cfg.frame_width[11:1]});
  assign fw_s     = signed'({2'b00, cfg.frame_width});
  assign rh_s     = signed'({2'b00, cfg.roi_height});
  assign c_l      = half_s - CENTRE_HALF_SPAN;
  assign c_r      = half_s + CENTRE_HALF_SPAN;
  assign c_t      = (rh_s < BOX_Y_TOP) ? rh_s : BOX_Y_TOP;
  assign c_b      = (rh_s < BOX_Y_TOP) ? BOX_Y_TOP : rh_s;
  assign wide_x_r = fw_s - WIDE_X_INSET;
  assign wide_y_b = rh_s - WIDE_Y_INSET;
  assign w_l      = (wide_x_r < WIDE_X_INSET) ? wide_x_r : WIDE_X_INSET;
  assign w_r      = (wide_x_r < WIDE_X_INSET) ? WIDE_X_INSET : wide_x_r;
  assign w_t      = (wide_y_b < BOX_Y_TOP) ? wide_y_b : BOX_Y_TOP;
  assign w_b      = (wide_y_b < BOX_Y_TOP) ? BOX_Y_TOP : wide_y_b;

  // The window this item is tested against.
  assign t_l = q_entry.warm ? c_l : wx_min_r;
  assign t_r = q_entry.warm ? c_r : wx_max_r;
  assign t_t = q_entry.warm ? c_t : wy_min_r;
  assign t_b = q_entry.warm ? c_b : wy_max_r;

  assign in_box = (px_s >= 15'(t_l)) && (px_s <= 15'(t_r)) &&
                  (py_s >= 15'(t_t)) && (py_s <= 15'(t_b));
  assign inside_pt = inside_r && in_box;
  assign cmin_pt   = (px < cmin_r) ? px : cmin_r;
  assign cmax_pt   = (px > cmax_r) ? px : cmax_r;
  assign margin_s  = signed'({6'd0, cfg.side_margin});

  // End-of-frame decision; sums wrap to 14 bits.
  always_comb begin
    n_l   = t_l;
    n_r   = t_r;
    n_t   = t_t;
    n_b   = t_b;
    n_act = ACT_KEEP_NONE;
    priority if (acc_r != 8'd0 && (q_entry.warm || acc_r <= REFIT_MAX_COUNT)) begin
      n_l   = signed'(14'(fmin_r)) - margin_s;
      n_r   = signed'(14'(fmax_r)) + margin_s;
      n_act = ACT_REFIT;
    end else if (q_entry.warm || cnt_r == 8'd0) begin
      n_act = ACT_KEEP_NONE;
    end else if (acc_r > REFIT_MAX_COUNT) begin
      n_act = ACT_KEEP_MANY;
    end else begin
      n_l   = w_l;
      n_r   = w_r;
      n_t   = w_t;
      n_b   = w_b;
      n_act = ACT_RESET_WIDE;
    end
  end

  always_comb begin
    wx_min_nxt = wx_min_r;
    wx_max_nxt = wx_max_r;
    wy_min_nxt = wy_min_r;
    wy_max_nxt = wy_max_r;
    inside_nxt = inside_r;
    cmin_nxt   = cmin_r;
    cmax_nxt   = cmax_r;
    fmin_nxt   = fmin_r;
    fmax_nxt   = fmax_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    if (is_pt) begin
      if (q_entry.kind == KIND_LAST) begin
        cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 8'd1;
        if (inside_pt) begin
          acc_nxt  = (acc_r == COUNT_MAX) ? acc_r : acc_r + 8'd1;
          fmin_nxt = (cmin_pt < fmin_r) ? cmin_pt : fmin_r;
          fmax_nxt = (cmax_pt > fmax_r) ? cmax_pt : fmax_r;
        end
        inside_nxt = 1'b1;
        cmin_nxt   = COORD_ONES;
        cmax_nxt   = '0;
      end else begin
        inside_nxt = inside_pt;
        cmin_nxt   = cmin_pt;
        cmax_nxt   = cmax_pt;
      end
    end else if (do_eof) begin
      // An unfinished contour is dropped along with the frame totals.
      wx_min_nxt = n_l;
      wx_max_nxt = n_r;
      wy_min_nxt = n_t;
      wy_max_nxt = n_b;
      inside_nxt = 1'b1;
      cmin_nxt   = COORD_ONES;
      cmax_nxt   = '0;
      fmin_nxt   = COORD_ONES;
      fmax_nxt   = '0;
      acc_nxt    = '0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_min_r    <= '0;
      wx_max_r    <= '0;
      wy_min_r    <= '0;
      wy_max_r    <= '0;
      inside_r    <= 1'b1;
      cmin_r      <= COORD_ONES;
      cmax_r      <= '0;
      fmin_r      <= COORD_ONES;
      fmax_r      <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wx_min_r <= wx_min_nxt;
      wx_max_r <= wx_max_nxt;
      wy_min_r <= wy_min_nxt;
      wy_max_r <= wy_max_nxt;
      inside_r <= inside_nxt;
      cmin_r   <= cmin_nxt;
      cmax_r   <= cmax_nxt;
      fmin_r   <= fmin_nxt;
      fmax_r   <= fmax_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      if (do_eof) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_eof) begin
      o_l_r   <= n_l;
      o_r_r   <= n_r;
      o_t_r   <= n_t;
      o_b_r   <= n_b;
      o_acc_r <= acc_r;
      o_act_r <= n_act;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_act_r;
  assign out_tdata  = {o_acc_r, o_b_r, o_t_r, o_r_r, o_l_r};

endmodule

@@ rtl/lane_window_tracker_unit.sv @@
// Lane window tracker. Contour points stream in one item per cycle and are tested
// against the current search window; at each end-of-frame item the window is refit,
// kept or reset and one result item reports the new window, the accepted contour
// count and the action taken. The block sustains one item per clock as long as
// results are taken. An end-of-frame item waits at the head of the input queue
// while the previous result still sits unclaimed in the output register; items
// behind it fill the queue and then hold in_tready low.
// An accepted end-of-frame item is registered in the input queue and then in the output
// register that drives out_tvalid.
module lane_window_tracker_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // mode
  input  logic [39:0] in_tdata,    // point_x[11:0], point_y[23:12], frame_index[39:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,   // action
  output logic [63:0] out_tdata,   // win_left[13:0], win_right[27:14], win_top[41:28],
                                   // win_bottom[55:42], accepted_contours[63:56]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lwt_pkg::*;

  localparam int EW = $bits(lwt_entry_t);

  lwt_cfg_t         cfg;
  lwt_entry_t       push_entry, pop_entry;
  logic             q_push, q_pop, q_valid, q_full;
  logic [EW-1:0]    q_rdata;

  lwt_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lwt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  lwt_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_entry),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  assign pop_entry = q_rdata;

  lwt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lwt_pkg::*;

  localparam int STALL_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [13:0] left;
    logic [13:0] right;
    logic [13:0] top;
    logic [13:0] bottom;
    logic [7:0]  accepted;
    logic [1:0]  action;
  } window_report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = MODE_NONE;   // mode
  logic [39:0] in_tdata = '0;          // point_x, point_y, frame_index
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;              // action
  logic [63:0] out_tdata;              // win_left, win_right, win_top, win_bottom, accepted
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Register shadow, as the block holds it after reset.
  logic [11:0] cfg_fw = FRAME_WIDTH_RST;
  logic [11:0] cfg_rh = ROI_HEIGHT_RST;
  logic [7:0]  cfg_margin = SIDE_MARGIN_RST;
  logic [15:0] cfg_warm = WARMUP_FRAMES_RST;

  // Tracker state mirrored by the predictor.
  logic signed [13:0] win_x_lo = '0;
  logic signed [13:0] win_x_hi = '0;
  logic signed [13:0] win_y_lo = '0;
  logic signed [13:0] win_y_hi = '0;
  bit          cont_ok = 1'b1;
  logic [11:0] cont_lo_x = '1;
  logic [11:0] cont_hi_x = '0;
  logic [11:0] frm_lo_x = '1;
  logic [11:0] frm_hi_x = '0;
  logic [7:0]  acc_cnt = '0;
  logic [7:0]  cont_cnt = '0;

  window_report_t pending_windows[$];
  int fail_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stall_toggle = 1'b0;
  logic stall_seen = 1'b0;
  int stall_left = 0;

  lane_window_tracker_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("FAIL lane_window_tracker_unit");
    $finish;
  end

  // Window that points of frame fi are tested against.
  function automatic void test_window(input logic [15:0] fi, output int l, output int r,
                                      output int t, output int b);
    int half;
    int rh;
    int ytop;
    if (fi <= cfg_warm) begin
      half = int'(cfg_fw >> 1);
      rh = int'(cfg_rh);
      ytop = int'(BOX_Y_TOP);
      l = half - int'(CENTRE_HALF_SPAN);
      r = half + int'(CENTRE_HALF_SPAN);
      t = (rh < ytop) ? rh : ytop;
      b = (rh < ytop) ? ytop : rh;
    end else begin
      l = int'(win_x_lo);
      r = int'(win_x_hi);
      t = int'(win_y_lo);
      b = int'(win_y_hi);
    end
  endfunction

  function automatic void clear_contour();
    cont_ok = 1'b1;
    cont_lo_x = '1;
    cont_hi_x = '0;
  endfunction

  task automatic track_item(input logic [1:0] mode, input logic [11:0] px,
                            input logic [11:0] py, input logic [15:0] fi);
    int l, r, t, b, xi, yi, x0, x1, y0, y1;
    bit warm;
    logic [1:0] act;
    window_report_t rep;
    if (mode == MODE_NONE) return;
    warm = (fi <= cfg_warm);
    test_window(fi, l, r, t, b);
    xi = int'(px);
    yi = int'(py);
    if (mode != MODE_EOF) begin
      if (!(xi >= l && xi <= r && yi >= t && yi <= b)) cont_ok = 1'b0;
      if (px < cont_lo_x) cont_lo_x = px;
      if (px > cont_hi_x) cont_hi_x = px;
      if (mode == MODE_LAST) begin
        if (cont_cnt != COUNT_MAX) cont_cnt++;
        if (cont_ok) begin
          if (acc_cnt != COUNT_MAX) acc_cnt++;
          if (cont_lo_x < frm_lo_x) frm_lo_x = cont_lo_x;
          if (cont_hi_x > frm_hi_x) frm_hi_x = cont_hi_x;
        end
        clear_contour();
      end
      return;
    end
    if (acc_cnt >= 1 && (warm || acc_cnt <= REFIT_MAX_COUNT)) begin
      l = int'(frm_lo_x) - int'(cfg_margin);
      r = int'(frm_hi_x) + int'(cfg_margin);
      act = ACT_REFIT;
    end else if (warm || cont_cnt == 0) begin
      act = ACT_KEEP_NONE;
    end else if (acc_cnt > REFIT_MAX_COUNT) begin
      act = ACT_KEEP_MANY;
    end else begin
      x0 = int'(WIDE_X_INSET);
      x1 = int'(cfg_fw) - int'(WIDE_X_INSET);
      y0 = int'(BOX_Y_TOP);
      y1 = int'(cfg_rh) - int'(WIDE_Y_INSET);
      l = (x0 < x1) ? x0 : x1;
      r = (x0 < x1) ? x1 : x0;
      t = (y0 < y1) ? y0 : y1;
      b = (y0 < y1) ? y1 : y0;
      act = ACT_RESET_WIDE;
    end
    win_x_lo = l[13:0];
    win_x_hi = r[13:0];
    win_y_lo = t[13:0];
    win_y_hi = b[13:0];
    rep.left = win_x_lo;
    rep.right = win_x_hi;
    rep.top = win_y_lo;
    rep.bottom = win_y_hi;
    rep.accepted = acc_cnt;
    rep.action = act;
    pending_windows.insert(pending_windows.size(), rep);
    clear_contour();
    frm_lo_x = '1;
    frm_hi_x = '0;
    acc_cnt = '0;
    cont_cnt = '0;
  endtask

  task automatic send_item(input logic [1:0] mode, input logic [11:0] px,
                           input logic [11:0] py, input logic [15:0] fi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {fi, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_item(mode, px, py, fi);
    if (mode != MODE_NONE) items_sent++;
  endtask

  // Drops valid, waits for every window report, then lets the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   cfg_fw = value[11:0];
      REG_ROI_HEIGHT:    cfg_rh = value[11:0];
      REG_SIDE_MARGIN:   cfg_margin = value[7:0];
      REG_WARMUP_FRAMES: cfg_warm = value[15:0];
      default: ;
    endcase
  endtask

  // One frame of n_cont contours; in_pct is the chance that a point falls inside the
  // window, and the last contour is sometimes left open so the frame drops it.
  task automatic send_frame(input logic [15:0] fi, input int n_cont, input int in_pct);
    int l, r, t, b, npts;
    bit fits, open_tail;
    logic [11:0] x, y;
    logic [1:0] mode;
    test_window(fi, l, r, t, b);
    fits = (l <= r) && (t <= b) && (r >= 0) && (b >= 0) && (l <= 4095) && (t <= 4095);
    open_tail = ($urandom_range(9) == 0);
    for (int c = 0; c < n_cont; c++) begin
      npts = $urandom_range(4, 1);
      for (int p = 0; p < npts; p++) begin
        if ($urandom_range(19) == 0) begin
          send_item(MODE_NONE, 12'($urandom), 12'($urandom), 16'($urandom));
        end
        if (fits && $urandom_range(99) < in_pct) begin
          x = 12'($urandom_range((r > 4095) ? 4095 : r, (l < 0) ? 0 : l));
          y = 12'($urandom_range((b > 4095) ? 4095 : b, (t < 0) ? 0 : t));
        end else begin
          x = 12'($urandom);
          y = 12'($urandom);
        end
        mode = (p == npts - 1 && !(open_tail && c == n_cont - 1)) ? MODE_LAST : MODE_POINT;
        send_item(mode, x, y, fi);
      end
    end
    send_item(MODE_EOF, 12'($urandom), 12'($urandom), fi);
  endtask

  // Reset settings: the warm-up box is x 220..420, y 2..160.
  task automatic test_directed();
    // Warm-up frame: one contour touching opposite corners, one just outside,
    // one left open.
    send_item(MODE_POINT, 12'd220, 12'd2, 16'd0);
    send_item(MODE_LAST, 12'd420, 12'd160, 16'd0);
    send_item(MODE_LAST, 12'd219, 12'd50, 16'd0);
    send_item(MODE_POINT, 12'd300, 12'd100, 16'd0);
    send_item(MODE_EOF, 12'd0, 12'd0, 16'd0);
    // Warm-up frame without contours falls back to the centred box.
    send_item(MODE_EOF, 12'hFFF, 12'hFFF, 16'd5);
    // Later frame with only rejected contours resets to the wide box.
    send_item(MODE_LAST, 12'd421, 12'd10, 16'd21);
    send_item(MODE_LAST, 12'd300, 12'd161, 16'd21);
    send_item(MODE_EOF, 12'd0, 12'd0, 16'd21);
    // Later frame without contours keeps the window.
    send_item(MODE_EOF, 12'd0, 12'd0, 16'd22);
    // Five accepted contours are too many to refit.
    for (int i = 0; i < 5; i++) send_item(MODE_LAST, 12'd100 + 12'(i), 12'd50, 16'd23);
    send_item(MODE_EOF, 12'd0, 12'd0, 16'd23);
    // Contour on the wide box edges refits.
    send_item(MODE_POINT, 12'd30, 12'd2, 16'd24);
    send_item(MODE_LAST, 12'd610, 12'd158, 16'd24);
    send_item(MODE_EOF, 12'd0, 12'd0, 16'd24);
    // Ignored mode ahead of contours at the coordinate extremes on the last frame index.
    send_item(MODE_NONE, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_item(MODE_LAST, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_item(MODE_LAST, 12'd0, 12'd0, 16'hFFFF);
    send_item(MODE_EOF, 12'hFFF, 12'hFFF, 16'hFFFF);
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 258; i++) send_item(MODE_LAST, 12'd320, 12'd80, 16'd1);
    send_item(MODE_EOF, 12'd0, 12'd0, 16'd1);
  endtask

  // The receiver stops for a long stretch so end-of-frame items back up.
  task automatic test_backpressure();
    stall_toggle <= ~stall_toggle;
    for (int i = 0; i < 12; i++) send_frame(16'd0, 1, 100);
  endtask

  task automatic test_random_phase(input int ph);
    int fw_set[6]   = '{640, 4095, 1, 100, 2000, 59};
    int rh_set[6]   = '{160, 4095, 1, 3, 600, 4095};
    int mg_set[6]   = '{20, 255, 0, 7, 128, 1};
    int warm_set[6] = '{20, 0, 65535, 300, 5, 1000};
    int target, n_cont, in_pct, pick;
    logic [15:0] fi;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, fw_set[ph]);
    write_reg(REG_ROI_HEIGHT, rh_set[ph]);
    write_reg(REG_SIDE_MARGIN, mg_set[ph]);
    write_reg(REG_WARMUP_FRAMES, warm_set[ph]);
    if (ph < 2) begin
      send_idle_pct = 28;
      recv_idle_pct = 54;
    end else if (ph < 4) begin
      send_idle_pct = 54;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    target = items_sent + 35;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 35 || cfg_warm == 16'hFFFF) fi = 16'($urandom_range(cfg_warm, 0));
      else if (pick < 90) fi = 16'($urandom_range(65535, int'(cfg_warm) + 1));
      else fi = 16'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) n_cont = 0;
      else if (pick < 3) n_cont = $urandom_range(8, 5);
      else n_cont = $urandom_range(4, 1);
      pick = $urandom_range(9);
      in_pct = (pick < 6) ? 95 : (pick < 8) ? 50 : 0;
      send_frame(fi, n_cont, in_pct);
    end
  endtask

  always @(posedge clk) begin
    if (stall_toggle != stall_seen) begin
      stall_seen <= stall_toggle;
      stall_left <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [13:0] want,
                             input logic [13:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    window_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_windows.size() == 0) begin
        $error("window report with nothing expected: tdata %h tuser %h", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_windows.pop_front();
        check_field("win_left", want.left, out_tdata[13:0]);
        check_field("win_right", want.right, out_tdata[27:14]);
        check_field("win_top", want.top, out_tdata[41:28]);
        check_field("win_bottom", want.bottom, out_tdata[55:42]);
        check_field("accepted_contours", 14'(want.accepted), 14'(out_tdata[63:56]));
        check_field("action", 14'(want.action), 14'(out_tuser));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 54;
    test_directed();
    test_count_saturation();
    test_backpressure();
    for (int ph = 0; ph < 6; ph++) test_random_phase(ph);
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS lane_window_tracker_unit");
    end else begin
      $display("FAIL lane_window_tracker_unit");
    end
    $finish;
  end

endmodule
